@@ src/lkft_pkg.sv @@
`timescale 1ns / 1ps
package lkft_pkg;
   localparam int MAX_ENTRIES_DEF    = 8;
   localparam int FRAGMENT_SLOTS_DEF = 32;
   localparam int NAME_BYTES_DEF     = 10;
   localparam int CARRIED_BYTES      = 10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic compact;
      logic search;
      logic commit;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic done;
   } stat_type;
endpackage

@@ src/lkft_ctrl.sv @@
`timescale 1ns / 1ps
module lkft_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  lkft_pkg::stat_type stat,
   output lkft_pkg::cmd_type  cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_COMPACT, ST_SEARCH, ST_COMMIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            cmd.compact = 1'b1;
            state_in    = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = !stat.empty;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one command");
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid) else $error("emit without valid");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_COMPACT) else $error("load not followed");
endmodule

@@ src/lkft_datapath.sv @@
`timescale 1ns / 1ps
module lkft_datapath #(
   parameter int MAX_ENTRIES    = lkft_pkg::MAX_ENTRIES_DEF,
   parameter int FRAGMENT_SLOTS = lkft_pkg::FRAGMENT_SLOTS_DEF,
   parameter int NAME_BYTES     = lkft_pkg::NAME_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lkft_pkg::cmd_type  cmd,
   output lkft_pkg::stat_type stat,
   input  logic [63:0]        req_name_low,
   input  logic [15:0]        req_name_high,
   input  logic [7:0]         req_fragment_index,
   input  logic [31:0]        req_now_time,
   input  logic [31:0]        req_purpose_mask,
   output logic               rsp_status,
   output logic [2:0]         rsp_slot,
   output logic [7:0]         rsp_entry_id,
   output logic               rsp_is_new,
   output logic               rsp_evicted,
   output logic               rsp_frag_write,
   output logic [7:0]         rsp_frag_addr,
   output logic [31:0]        rsp_valid_flags,
   output logic               rsp_purpose_met
);
   localparam int SW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int LB = (NAME_BYTES < lkft_pkg::CARRIED_BYTES) ?
                       NAME_BYTES : lkft_pkg::CARRIED_BYTES;

   // request hold
   logic [79:0] raw_ff;
   logic [7:0]  index_ff;
   logic [31:0] now_ff, mask_ff;
   logic [63:0] key_lo_ff, key_lo_in;
   logic [15:0] key_hi_ff, key_hi_in;
   logic        empty_ff, empty_in;

   // table
   logic                   used_ff [MAX_ENTRIES];
   logic [63:0]            klo_ff  [MAX_ENTRIES];
   logic [15:0]            khi_ff  [MAX_ENTRIES];
   logic [31:0]            stamp_ff[MAX_ENTRIES];
   logic [31:0]            flags_ff[MAX_ENTRIES];
   logic [SW-1:0]          rank_ff [MAX_ENTRIES];
   logic [7:0]             ident_ff[MAX_ENTRIES];
   logic [7:0]             next_id_ff;

   // sequential scan
   logic [CW-1:0] scan_ff;
   logic [SW-1:0] scan_idx;
   logic          hit_ok_ff, free_ok_ff, vic_ok_ff;
   logic [SW-1:0] hit_ff, free_ff, vic_ff;
   logic [CW-1:0] used_cnt_ff;

   // commit stage, kept apart from the output register
   logic [SW-1:0] c_tgt_ff;
   logic          c_new_ff, c_evict_ff, c_fw_ff;
   logic [7:0]    c_id_ff, c_addr_ff;

   // result
   logic        r_status_ff, r_new_ff, r_evict_ff, r_fw_ff, r_met_ff;
   logic [2:0]  r_slot_ff;
   logic [7:0]  r_id_ff, r_addr_ff;
   logic [31:0] r_flags_ff;

   // compaction over the held bytes
   always_comb begin
      logic [7:0]  b;
      logic [4:0]  len;
      logic        stop;
      key_lo_in = '0;
      key_hi_in = '0;
      len       = '0;
      stop      = 1'b0;
      for (int i = 0; i < LB; i++) begin
         b = raw_ff[8*i +: 8];
         if (b == lkft_pkg::CHAR_NUL) begin
            stop = 1'b1;
         end
         if (!stop && b != lkft_pkg::CHAR_SPACE) begin
            for (int j = 0; j < 10; j++) begin
               if (len == 5'(j)) begin
                  if (j < 8) key_lo_in[8*j +: 8] = b;
                  else key_hi_in[8*(j-8) +: 8] = b;
               end
            end
            len = len + 5'd1;
         end
      end
      empty_in = (len == 5'd0);
   end

   assign scan_idx  = scan_ff[SW-1:0];
   assign stat.done = (scan_ff == CW'(MAX_ENTRIES - 1));
   assign stat.empty = empty_ff;

   logic [SW-1:0] tgt;
   logic          full;
   assign full = (used_cnt_ff == CW'(MAX_ENTRIES));
   assign tgt  = hit_ok_ff ? hit_ff : (full ? vic_ff : free_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff   <= {req_name_high, req_name_low};
         index_ff <= req_fragment_index;
         now_ff   <= req_now_time;
         mask_ff  <= req_purpose_mask;
      end
      if (cmd.compact) begin
         key_lo_ff   <= key_lo_in;
         key_hi_ff   <= key_hi_in;
         empty_ff    <= empty_in;
         scan_ff     <= '0;
         hit_ok_ff   <= 1'b0;
         free_ok_ff  <= 1'b0;
         vic_ok_ff   <= 1'b0;
         used_cnt_ff <= '0;
      end
      // one slot per cycle: match, first free, oldest
      if (cmd.search) begin
         if (!stat.done) scan_ff <= scan_ff + CW'(1);
         if (used_ff[scan_idx]) begin
            used_cnt_ff <= used_cnt_ff + CW'(1);
            if (!hit_ok_ff && klo_ff[scan_idx] == key_lo_ff &&
                khi_ff[scan_idx] == key_hi_ff) begin
               hit_ok_ff <= 1'b1;
               hit_ff    <= scan_idx;
            end
         end else if (!free_ok_ff) begin
            free_ok_ff <= 1'b1;
            free_ff    <= scan_idx;
         end
         if (!vic_ok_ff || stamp_ff[scan_idx] < stamp_ff[vic_ff] ||
             (stamp_ff[scan_idx] == stamp_ff[vic_ff] &&
              rank_ff[scan_idx] < rank_ff[vic_ff])) begin
            vic_ok_ff <= 1'b1;
            vic_ff    <= scan_idx;
         end
      end
      if (cmd.commit) begin
         if (!hit_ok_ff) begin
            for (int s = 0; s < MAX_ENTRIES; s++) begin
               if (full && used_ff[s] && rank_ff[s] > rank_ff[vic_ff]) begin
                  rank_ff[s] <= rank_ff[s] - SW'(1);
               end
            end
            klo_ff[tgt]   <= key_lo_ff;
            khi_ff[tgt]   <= key_hi_ff;
            rank_ff[tgt]  <= full ? SW'(MAX_ENTRIES - 1) : used_cnt_ff[SW-1:0];
            ident_ff[tgt] <= next_id_ff;
         end
         if (index_ff < 8'(FRAGMENT_SLOTS)) begin
            flags_ff[tgt] <= (hit_ok_ff ? flags_ff[tgt] : 32'd0) |
                             (32'd1 << index_ff[4:0]);
         end else if (!hit_ok_ff) begin
            flags_ff[tgt] <= '0;
         end
         stamp_ff[tgt] <= now_ff;
         c_tgt_ff   <= tgt;
         c_new_ff   <= !hit_ok_ff;
         c_evict_ff <= !hit_ok_ff && full;
         c_fw_ff    <= index_ff < 8'(FRAGMENT_SLOTS);
         c_addr_ff  <= (index_ff < 8'(FRAGMENT_SLOTS)) ?
                       8'(32'(tgt) * FRAGMENT_SLOTS + 32'(index_ff)) : 8'd0;
         c_id_ff    <= hit_ok_ff ? ident_ff[tgt] : next_id_ff;
      end
      if (cmd.emit) begin
         r_status_ff <= empty_ff;
         if (empty_ff) begin
            r_slot_ff  <= '0;
            r_id_ff    <= '0;
            r_new_ff   <= 1'b0;
            r_evict_ff <= 1'b0;
            r_fw_ff    <= 1'b0;
            r_addr_ff  <= '0;
            r_flags_ff <= '0;
            r_met_ff   <= 1'b0;
         end else begin
            r_slot_ff  <= 3'(c_tgt_ff);
            r_id_ff    <= c_id_ff;
            r_new_ff   <= c_new_ff;
            r_evict_ff <= c_evict_ff;
            r_fw_ff    <= c_fw_ff;
            r_addr_ff  <= c_addr_ff;
            r_flags_ff <= flags_ff[c_tgt_ff];
            r_met_ff   <= (flags_ff[c_tgt_ff] & mask_ff) == mask_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= '0;
         for (int s = 0; s < MAX_ENTRIES; s++) used_ff[s] <= 1'b0;
      end else if (cmd.commit && !hit_ok_ff) begin
         used_ff[tgt] <= 1'b1;
         next_id_ff   <= next_id_ff + 8'd1;
      end
   end

   assign rsp_status      = r_status_ff;
   assign rsp_slot        = r_slot_ff;
   assign rsp_entry_id    = r_id_ff;
   assign rsp_is_new      = r_new_ff;
   assign rsp_evicted     = r_evict_ff;
   assign rsp_frag_write  = r_fw_ff;
   assign rsp_frag_addr   = r_addr_ff;
   assign rsp_valid_flags = r_flags_ff;
   assign rsp_purpose_met = r_met_ff;

   a_no_commit_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !empty_ff) else $error("commit on empty name");
   a_new_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !hit_ok_ff && !full |-> free_ok_ff) else $error("no free slot");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.search |-> scan_ff < CW'(MAX_ENTRIES)) else $error("scan overrun");
endmodule

@@ src/lru_keyed_fragment_tracker.sv @@
`timescale 1ns / 1ps
// Keyed fragment tracker with least-recently-used replacement over a slot table.
// req_ channel: one word per calibration fragment: raw name, fragment index,
// current time and purpose mask. rsp_ channel: one word per request with slot,
// entry id, new/evicted flags, external write address and valid flags.
// An empty name (only spaces or NUL) returns status 1 and changes nothing.
// From req accept to rsp_valid the tracker compacts the name, compares one slot
// per cycle against the table, updates the table and loads the output register.
// A request is not taken before the previous one has reached the output
// register; req_ready is high only while the controller is idle.
// A result waits in the output register while rsp_ready is low; the next
// request is taken meanwhile and its result holds until the register frees.
// Reset (synchronous, active high) empties the table, restarts entry ids at
// zero and drops any pending result.
module lru_keyed_fragment_tracker #(
   parameter int MAX_ENTRIES    = lkft_pkg::MAX_ENTRIES_DEF,
   parameter int FRAGMENT_SLOTS = lkft_pkg::FRAGMENT_SLOTS_DEF,
   parameter int NAME_BYTES     = lkft_pkg::NAME_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_name_low,
   input  logic [15:0] req_name_high,
   input  logic [7:0]  req_fragment_index,
   input  logic [31:0] req_now_time,
   input  logic [31:0] req_purpose_mask,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [2:0]  rsp_slot,
   output logic [7:0]  rsp_entry_id,
   output logic        rsp_is_new,
   output logic        rsp_evicted,
   output logic        rsp_frag_write,
   output logic [7:0]  rsp_frag_addr,
   output logic [31:0] rsp_valid_flags,
   output logic        rsp_purpose_met
);
   lkft_pkg::cmd_type  cmd;
   lkft_pkg::stat_type stat;

   lkft_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   lkft_datapath #(
      .MAX_ENTRIES(MAX_ENTRIES), .FRAGMENT_SLOTS(FRAGMENT_SLOTS),
      .NAME_BYTES(NAME_BYTES)
   ) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_name_low, .req_name_high, .req_fragment_index, .req_now_time,
      .req_purpose_mask, .rsp_status, .rsp_slot, .rsp_entry_id, .rsp_is_new,
      .rsp_evicted, .rsp_frag_write, .rsp_frag_addr, .rsp_valid_flags,
      .rsp_purpose_met
   );
endmodule
